// ===== rtl/sagp_pkg.sv =====
// Shared types, constants and arithmetic step functions for the spatial
// audio gain and pan core. No dependencies.
package sagp_pkg;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_POSITION = 2'd0;
  localparam logic [1:0] REG_FORWARD  = 2'd1;
  localparam logic [1:0] REG_UP       = 2'd2;

  // Register reset values: listener at origin, forward +z, up +y
  localparam logic [59:0] POSITION_RST = 60'h0;
  localparam logic [47:0] FORWARD_RST  = 48'h4000_0000_0000;
  localparam logic [47:0] UP_RST       = 48'h0000_4000_0000;

  // Side vector that matches the reset directions (+x, Q1.14)
  localparam logic [15:0] SIDE_X_RST = 16'h4000;

  // Q1.15 output codes
  localparam logic [15:0] ONE_Q15  = 16'h8000;
  localparam logic [15:0] PAN_MAX  = 16'h7FFF;
  localparam logic [15:0] PAN_LEFT = 16'h8000;

  // One digit of a square root: radicand, partial remainder, partial root
  typedef struct packed {
    logic [63:0] v;
    logic [34:0] rem;
    logic [31:0] root;
  } sqrt_t;

  // One bit of a restoring division: partial remainder, divisor, quotient
  typedef struct packed {
    logic [47:0] rem;
    logic [31:0] den;
    logic [15:0] quo;
  } div_t;

  // Side vector unit status toward the datapath
  typedef struct packed {
    logic             busy;
    logic [2:0][15:0] comp;
  } side_t;

  // Retire radicand bit pair b into the root
  function automatic sqrt_t sqrt_step(input sqrt_t s, input logic [4:0] b);
    sqrt_t       r;
    logic [34:0] rem_sh;
    logic [34:0] trial;
    rem_sh = {s.rem[32:0], s.v[{b, 1'b0} +: 2]};
    trial  = {1'b0, s.root, 2'b01};
    r.v    = s.v;
    if (rem_sh >= trial) begin
      r.rem  = rem_sh - trial;
      r.root = {s.root[30:0], 1'b1};
    end else begin
      r.rem  = rem_sh;
      r.root = {s.root[30:0], 1'b0};
    end
    return r;
  endfunction

  // Decide quotient bit i
  function automatic div_t div_step(input div_t s, input logic [3:0] i);
    div_t        r;
    logic [47:0] d_sh;
    d_sh = {16'b0, s.den} << i;
    r    = s;
    if (s.rem >= d_sh) begin
      r.rem    = s.rem - d_sh;
      r.quo[i] = 1'b1;
    end
    return r;
  endfunction

endpackage

// ===== rtl/spatial_audio_gain_pan_core.sv =====
// Top level of the spatial audio gain and pan core: register file,
// 56-stage datapath and output register. Uses sagp_pkg and sagp_side_unit.
//
// One source transaction is accepted per clock cycle while in_stall_o is low;
// each result passes through the 56 pipeline stages, the first loaded at the
// edge that accepts its source, and then the output register. The depth is
// mostly set by two 32-stage square roots followed by two 16-stage dividers.
// The pipeline keeps moving while a finished result waits at the output,
// until the last stage fills. Writing listener_forward or listener_up starts
// a recompute of the side vector in a shared iterative square root and
// divider; the input stalls while it runs.
module spatial_audio_gain_pan_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready,
  // Source channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [19:0] source_x_i,
  input  logic signed [19:0] source_y_i,
  input  logic signed [19:0] source_z_i,
  input  logic [23:0]        near_distance_i,
  input  logic [23:0]        far_distance_i,
  input  logic [4:0]         source_tag_i,
  // Result channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [15:0]        gain_o,
  output logic signed [15:0] pan_o,
  output logic               pan_valid_o,
  output logic [4:0]         result_tag_o
);

  localparam int SQ_FIRST = 8;
  localparam int SQ_N     = 32;
  localparam int PREP     = SQ_FIRST + SQ_N;
  localparam int DV_N     = 16;
  localparam int LAST     = PREP + DV_N;

  typedef struct packed {
    logic [4:0]  tag;
    logic [23:0] near;
    logic [31:0] span;
    logic        near_hit;
    logic        far_hit;
    logic        span_zero;
    logic        xpos;
    logic        hzero;
    logic [30:0] axs;
  } carry_t;

  // Configuration registers
  logic [59:0]       pos_q;
  logic [47:0]       fwd_q;
  logic [47:0]       up_q;
  logic              wr_en;
  logic [1:0]        reg_idx;
  sagp_pkg::side_t   side;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:3];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= sagp_pkg::POSITION_RST;
      fwd_q <= sagp_pkg::FORWARD_RST;
      up_q  <= sagp_pkg::UP_RST;
    end else if (wr_en) begin
      case (reg_idx)
        sagp_pkg::REG_POSITION: pos_q <= pwdata[59:0];
        sagp_pkg::REG_FORWARD:  fwd_q <= pwdata[47:0];
        sagp_pkg::REG_UP:       up_q  <= pwdata[47:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (reg_idx)
      sagp_pkg::REG_POSITION: prdata = {4'b0, pos_q};
      sagp_pkg::REG_FORWARD:  prdata = {16'b0, fwd_q};
      sagp_pkg::REG_UP:       prdata = {16'b0, up_q};
      default:                prdata = '0;
    endcase
  end

  sagp_side_unit u_side (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (wr_en && (reg_idx == sagp_pkg::REG_FORWARD ||
                        reg_idx == sagp_pkg::REG_UP)),
    .fwd_i   (fwd_q),
    .up_i    (up_q),
    .side_o  (side)
  );

  // Flow control: advance unless the last stage is blocked
  logic            out_valid_q;
  logic            out_ready;
  logic            en;
  logic            in_acc;
  logic [LAST:1]   vld_q;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign en         = out_ready || !vld_q[LAST];
  assign in_stall_o = !en || side.busy;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (en) vld_q <= {vld_q[LAST-1:1], in_acc};
      if (out_ready) out_valid_q <= vld_q[LAST];
    end
  end

  // Stage 1: offset from listener
  logic signed [20:0] off_q [3];
  logic [23:0]        near1_q, far1_q;
  logic [4:0]         tag1_q;
  logic signed [19:0] src [3];

  assign src[0] = source_x_i;
  assign src[1] = source_y_i;
  assign src[2] = source_z_i;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++)
        off_q[k] <= 21'(src[k]) - 21'($signed(pos_q[20*k +: 20]));
      near1_q <= near_distance_i;
      far1_q  <= far_distance_i;
      tag1_q  <= source_tag_i;
    end
  end

  // Stage 2: squares and dot product terms
  logic [40:0]        sqr_q [3];
  logic signed [36:0] xp_q [3];
  logic signed [36:0] yp_q [3];
  logic [47:0]        near2_q, far2_q;
  logic [23:0]        near2d_q, far2d_q;
  logic [4:0]         tag2_q;
  logic signed [41:0] osq [3];

  always_comb begin
    for (int k = 0; k < 3; k++) osq[k] = off_q[k] * off_q[k];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        sqr_q[k] <= osq[k][40:0];
        xp_q[k]  <= off_q[k] * $signed(side.comp[k]);
        yp_q[k]  <= off_q[k] * $signed(fwd_q[16*k +: 16]);
      end
      near2_q  <= near1_q * near1_q;
      far2_q   <= far1_q * far1_q;
      near2d_q <= near1_q;
      far2d_q  <= far1_q;
      tag2_q   <= tag1_q;
    end
  end

  // Stage 3: sums and region tests
  carry_t             sb_q [3:LAST];
  logic [41:0]        d2_q [3:6];
  logic signed [38:0] x3_q, y3_q;
  logic [41:0]        d2_sum;
  logic               near_hit;

  assign d2_sum   = 42'(sqr_q[0]) + 42'(sqr_q[1]) + 42'(sqr_q[2]);
  assign near_hit = {6'b0, d2_sum} < near2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      d2_q[3]           <= d2_sum;
      x3_q              <= 39'(xp_q[0]) + 39'(xp_q[1]) + 39'(xp_q[2]);
      y3_q              <= 39'(yp_q[0]) + 39'(yp_q[1]) + 39'(yp_q[2]);
      sb_q[3].tag       <= tag2_q;
      sb_q[3].near      <= near2d_q;
      sb_q[3].span      <= {24'(far2d_q - near2d_q), 8'b0};
      sb_q[3].near_hit  <= near_hit;
      sb_q[3].far_hit   <= !near_hit && ({6'b0, d2_sum} > far2_q);
      sb_q[3].span_zero <= (far2d_q == near2d_q);
      sb_q[3].xpos      <= 1'b0;
      sb_q[3].hzero     <= 1'b0;
      sb_q[3].axs       <= '0;
    end
  end

  // Stage 4: magnitudes and sign of x
  logic [37:0]        ax_q, ay_q;
  logic signed [38:0] x_neg, y_neg;
  carry_t             sb4_d;

  assign x_neg = -x3_q;
  assign y_neg = -y3_q;

  always_comb begin
    sb4_d      = sb_q[3];
    sb4_d.xpos = !x3_q[38] && (x3_q != '0);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ax_q    <= x3_q[38] ? x_neg[37:0] : x3_q[37:0];
      ay_q    <= y3_q[38] ? y_neg[37:0] : y3_q[37:0];
      d2_q[4] <= d2_q[3];
      sb_q[4] <= sb4_d;
    end
  end

  // Stage 5: scale both below 2^31
  logic [30:0] axs_q, ays_q;
  logic [37:0] ax_or;
  logic [2:0]  sh;
  carry_t      sb5_d;

  always_comb begin
    ax_or = ax_q | ay_q;
    sh    = '0;
    for (int i = 0; i < 7; i++) if (ax_or[31+i]) sh = 3'(i + 1);
    sb5_d     = sb_q[4];
    sb5_d.axs = 31'(ax_q >> sh);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      axs_q   <= 31'(ax_q >> sh);
      ays_q   <= 31'(ay_q >> sh);
      d2_q[5] <= d2_q[4];
      sb_q[5] <= sb5_d;
    end
  end

  // Stage 6: squares of scaled dot products
  logic [61:0] sqx_q, sqy_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sqx_q   <= axs_q * axs_q;
      sqy_q   <= ays_q * ays_q;
      d2_q[6] <= d2_q[5];
      sb_q[6] <= sb_q[5];
    end
  end

  // Stage 7: load both square root radicands
  sagp_pkg::sqrt_t dsq_q [SQ_FIRST-1:PREP-1];
  sagp_pkg::sqrt_t hsq_q [SQ_FIRST-1:PREP-1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      dsq_q[SQ_FIRST-1].v    <= {6'b0, d2_q[6], 16'b0};
      dsq_q[SQ_FIRST-1].rem  <= '0;
      dsq_q[SQ_FIRST-1].root <= '0;
      hsq_q[SQ_FIRST-1].v    <= {1'b0, 63'({1'b0, sqx_q} + {1'b0, sqy_q})};
      hsq_q[SQ_FIRST-1].rem  <= '0;
      hsq_q[SQ_FIRST-1].root <= '0;
      sb_q[SQ_FIRST-1]       <= sb_q[6];
    end
  end

  // Square root stages: one root bit each
  for (genvar j = SQ_FIRST; j < PREP; j++) begin : g_sqrt
    always_ff @(posedge clk_i) begin
      if (en) begin
        dsq_q[j] <= sagp_pkg::sqrt_step(dsq_q[j-1], 5'(PREP - 1 - j));
        hsq_q[j] <= sagp_pkg::sqrt_step(hsq_q[j-1], 5'(PREP - 1 - j));
        sb_q[j]  <= sb_q[j-1];
      end
    end
  end

  // Divider setup: rounded numerators for gain and pan
  sagp_pkg::div_t gdv_q [PREP:LAST];
  sagp_pkg::div_t pdv_q [PREP:LAST];
  logic [31:0]    dist_root, hyp, num;
  carry_t         sbp_d;

  assign dist_root = dsq_q[PREP-1].root;
  assign hyp       = hsq_q[PREP-1].root;
  assign num       = dist_root - {sb_q[PREP-1].near, 8'b0};

  always_comb begin
    sbp_d       = sb_q[PREP-1];
    sbp_d.hzero = (hyp == '0);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      gdv_q[PREP].rem   <= ({16'b0, num} << 15) + {17'b0, sb_q[PREP-1].span[31:1]};
      gdv_q[PREP].den   <= sb_q[PREP-1].span;
      gdv_q[PREP].quo   <= '0;
      pdv_q[PREP].rem   <= ({17'b0, sb_q[PREP-1].axs} << 15) + {17'b0, hyp[31:1]};
      pdv_q[PREP].den   <= hyp;
      pdv_q[PREP].quo   <= '0;
      sb_q[PREP]        <= sbp_d;
    end
  end

  // Divider stages: one quotient bit each
  for (genvar j = PREP + 1; j <= LAST; j++) begin : g_div
    always_ff @(posedge clk_i) begin
      if (en) begin
        gdv_q[j] <= sagp_pkg::div_step(gdv_q[j-1], 4'(LAST - j));
        pdv_q[j] <= sagp_pkg::div_step(pdv_q[j-1], 4'(LAST - j));
        sb_q[j]  <= sb_q[j-1];
      end
    end
  end

  // Finish: region overrides, sign and saturation
  logic [15:0] gain_d, pan_d;
  logic        pv_d;
  logic [15:0] qg, qp;

  assign qg = gdv_q[LAST].quo;
  assign qp = pdv_q[LAST].quo;

  always_comb begin
    gain_d = '0;
    pan_d  = '0;
    pv_d   = 1'b0;
    if (sb_q[LAST].near_hit) begin
      gain_d = sagp_pkg::ONE_Q15;
    end else if (!sb_q[LAST].far_hit) begin
      pv_d   = 1'b1;
      gain_d = sb_q[LAST].span_zero ? sagp_pkg::ONE_Q15 : sagp_pkg::ONE_Q15 - qg;
      if (sb_q[LAST].hzero) pan_d = sagp_pkg::PAN_LEFT;
      else if (sb_q[LAST].xpos) pan_d = 16'(-qp);
      else if (qp > sagp_pkg::PAN_MAX) pan_d = sagp_pkg::PAN_MAX;
      else pan_d = qp;
    end
  end

  // Output register
  logic [15:0] gain_q, pan_q;
  logic        pv_q;
  logic [4:0]  rtag_q;

  always_ff @(posedge clk_i) begin
    if (out_ready && vld_q[LAST]) begin
      gain_q <= gain_d;
      pan_q  <= pan_d;
      pv_q   <= pv_d;
      rtag_q <= sb_q[LAST].tag;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign gain_o       = gain_q;
  assign pan_o        = $signed(pan_q);
  assign pan_valid_o  = pv_q;
  assign result_tag_o = rtag_q;

  // Checks
  a_pan_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !pan_valid_o |-> pan_o == '0)
    else $error("pan not cleared outside the near/far band");

  a_gain_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> gain_o <= sagp_pkg::ONE_Q15)
    else $error("gain above unity");

  a_gain_edges: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !pan_valid_o |-> (gain_o == '0 || gain_o == sagp_pkg::ONE_Q15))
    else $error("gain not full or zero outside the near/far band");

endmodule

// ===== rtl/sagp_side_unit.sv =====
// Sequential unit that derives the normalized listener side vector
// (up cross forward) after a direction register write. Uses sagp_pkg.
module sagp_side_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [47:0]          fwd_i,
  input  logic [47:0]          up_i,
  output sagp_pkg::side_t      side_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROD,
    ST_CROSS,
    ST_SQUARE,
    ST_SUM,
    ST_ROOT,
    ST_DIV_LOAD,
    ST_DIV_RUN
  } state_e;

  state_e                state_q;
  logic [4:0]            step_q;
  logic [1:0]            k_q;
  logic                  div_done_q;
  logic [15:0]           side_q [3];

  logic signed [31:0]    prod_q [6];
  logic signed [32:0]    c_q [3];
  logic [63:0]           sq_q [3];
  sagp_pkg::sqrt_t       sqrt_q;
  sagp_pkg::div_t        div_q;

  logic signed [15:0]    fw [3];
  logic signed [15:0]    up [3];
  logic signed [32:0]    c_sel;
  logic [31:0]           c_mag;
  logic [31:0]           c_mag_k [3];

  // Split direction fields; magnitudes of the cross product terms
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      fw[k] = $signed(fwd_i[16*k +: 16]);
      up[k] = $signed(up_i[16*k +: 16]);
      c_mag_k[k] = c_q[k][32] ? 32'(-c_q[k]) : c_q[k][31:0];
    end
    c_sel = c_q[k_q];
    c_mag = c_sel[32] ? 32'(-c_sel) : c_sel[31:0];
  end

  // Sequencer and side vector outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      step_q     <= '0;
      k_q        <= '0;
      div_done_q <= 1'b0;
      side_q[0]  <= sagp_pkg::SIDE_X_RST;
      side_q[1]  <= '0;
      side_q[2]  <= '0;
    end else if (start_i) begin
      state_q    <= ST_PROD;
      div_done_q <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE:   state_q <= ST_IDLE;
        ST_PROD:   state_q <= ST_CROSS;
        ST_CROSS:  state_q <= ST_SQUARE;
        ST_SQUARE: state_q <= ST_SUM;
        ST_SUM: begin
          state_q <= ST_ROOT;
          step_q  <= '0;
        end
        ST_ROOT: begin
          step_q <= step_q + 5'd1;
          if (step_q == 5'd31) begin
            state_q <= ST_DIV_LOAD;
            k_q     <= '0;
          end
        end
        ST_DIV_LOAD: begin
          // Finish the previous component before loading the next one
          if (div_done_q) begin
            side_q[k_q] <= c_sel[32] ? 16'(-div_q.quo) : div_q.quo;
            div_done_q  <= 1'b0;
            if (k_q == 2'd2) state_q <= ST_IDLE;
            else k_q <= k_q + 2'd1;
          end else if (sqrt_q.root == '0) begin
            side_q[k_q] <= '0;
            if (k_q == 2'd2) state_q <= ST_IDLE;
            else k_q <= k_q + 2'd1;
          end else begin
            state_q <= ST_DIV_RUN;
            step_q  <= '0;
          end
        end
        ST_DIV_RUN: begin
          step_q <= step_q + 5'd1;
          if (step_q == 5'd14) begin
            state_q    <= ST_DIV_LOAD;
            div_done_q <= 1'b1;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_PROD: begin
        prod_q[0] <= up[1] * fw[2];
        prod_q[1] <= up[2] * fw[1];
        prod_q[2] <= up[2] * fw[0];
        prod_q[3] <= up[0] * fw[2];
        prod_q[4] <= up[0] * fw[1];
        prod_q[5] <= up[1] * fw[0];
      end
      ST_CROSS: begin
        c_q[0] <= 33'(prod_q[0]) - 33'(prod_q[1]);
        c_q[1] <= 33'(prod_q[2]) - 33'(prod_q[3]);
        c_q[2] <= 33'(prod_q[4]) - 33'(prod_q[5]);
      end
      ST_SQUARE: begin
        for (int k = 0; k < 3; k++) sq_q[k] <= c_mag_k[k] * c_mag_k[k];
      end
      ST_SUM: begin
        sqrt_q.v    <= sq_q[0] + sq_q[1] + sq_q[2];
        sqrt_q.rem  <= '0;
        sqrt_q.root <= '0;
      end
      ST_ROOT: sqrt_q <= sagp_pkg::sqrt_step(sqrt_q, 5'd31 - step_q);
      ST_DIV_LOAD: begin
        div_q.rem <= ({16'b0, c_mag} << 14) + {17'b0, sqrt_q.root[31:1]};
        div_q.den <= sqrt_q.root;
        div_q.quo <= '0;
      end
      ST_DIV_RUN: div_q <= sagp_pkg::div_step(div_q, 4'(5'd14 - step_q));
      default: ;
    endcase
  end

  assign side_o.busy    = (state_q != ST_IDLE);
  assign side_o.comp[0] = side_q[0];
  assign side_o.comp[1] = side_q[1];
  assign side_o.comp[2] = side_q[2];

endmodule

// ===== tb/tb_spatial_audio_gain_pan_core.sv =====
// Self-checking testbench for spatial_audio_gain_pan_core: random and directed
// sources against a built-in distance gain and pan predictor. Uses sagp_pkg.
`timescale 1ns / 1ps

module tb_spatial_audio_gain_pan_core;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 120;
  localparam int ITEMS_PER_SET  = 370;

  typedef struct packed {
    logic signed [19:0] x;
    logic signed [19:0] y;
    logic signed [19:0] z;
    logic [23:0]        near_d;
    logic [23:0]        far_d;
    logic [4:0]         tag;
  } source_t;

  typedef struct packed {
    logic [15:0]        gain;
    logic signed [15:0] pan;
    logic               pan_valid;
    logic [4:0]         tag;
  } mix_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [4:0]         paddr = '0;
  logic [63:0]        pwdata = '0;
  logic [63:0]        prdata;
  logic               pready;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic signed [19:0] source_x_i = '0;
  logic signed [19:0] source_y_i = '0;
  logic signed [19:0] source_z_i = '0;
  logic [23:0]        near_distance_i = '0;
  logic [23:0]        far_distance_i = '0;
  logic [4:0]         source_tag_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [15:0]        gain_o;
  logic signed [15:0] pan_o;
  logic               pan_valid_o;
  logic [4:0]         result_tag_o;

  // Listener registers as the predictor sees them
  logic [59:0] lis_pos = sagp_pkg::POSITION_RST;
  logic [47:0] lis_fwd = sagp_pkg::FORWARD_RST;
  logic [47:0] lis_up  = sagp_pkg::UP_RST;

  source_t pending_q[$];
  mix_t    expected_mix_q[$];
  int      fail_cnt = 0;
  int      idle_cycles = 0;
  int      src_gap = 0;
  int      stall_len = 0;
  int      cyc = 0;
  logic    src_taken = 1'b0;

  spatial_audio_gain_pan_core dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_stall_o, .source_x_i, .source_y_i, .source_z_i,
    .near_distance_i, .far_distance_i, .source_tag_i,
    .out_valid_o, .out_stall_i, .gain_o, .pan_o, .pan_valid_o, .result_tag_o
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned mag(longint v);
    return (v < 0) ? longint'(0) - v : v;
  endfunction

  function automatic longint unsigned offset_sq(source_t s);
    longint o[3];
    longint unsigned d2;
    o[0] = longint'(s.x) - longint'($signed(lis_pos[19:0]));
    o[1] = longint'(s.y) - longint'($signed(lis_pos[39:20]));
    o[2] = longint'(s.z) - longint'($signed(lis_pos[59:40]));
    d2 = 0;
    for (int k = 0; k < 3; k++) d2 += mag(o[k]) * mag(o[k]);
    return d2;
  endfunction

  // Distance gain and stereo pan of one source against the current listener
  function automatic mix_t gain_pan(source_t s);
    longint          off[3], fw[3], up[3], c[3], side[3];
    longint unsigned d2, nr, fr, dist_root, span, num, cc, len, ax, ay, h, q;
    longint          x, y;
    int              sh;
    mix_t            r;
    off[0] = longint'(s.x) - longint'($signed(lis_pos[19:0]));
    off[1] = longint'(s.y) - longint'($signed(lis_pos[39:20]));
    off[2] = longint'(s.z) - longint'($signed(lis_pos[59:40]));
    d2 = 0;
    for (int k = 0; k < 3; k++) begin
      d2 += mag(off[k]) * mag(off[k]);
      fw[k] = longint'($signed(lis_fwd[16*k +: 16]));
      up[k] = longint'($signed(lis_up[16*k +: 16]));
      side[k] = 0;
    end
    nr = 64'(s.near_d);
    fr = 64'(s.far_d);
    r.gain = '0;
    r.pan = '0;
    r.pan_valid = 1'b0;
    r.tag = s.tag;
    if (d2 < nr * nr) begin
      r.gain = sagp_pkg::ONE_Q15;
    end else if (d2 > fr * fr) begin
      r.gain = '0;
    end else begin
      dist_root = isqrt(d2 << 16);
      span = (fr - nr) << 8;
      if (span == 0) begin
        r.gain = sagp_pkg::ONE_Q15;
      end else begin
        num = dist_root - (nr << 8);
        r.gain = 16'(64'd32768 - (num * 32768 + span / 2) / span);
      end
      // Side vector: up cross forward, normalized, zero stays zero
      c[0] = up[1] * fw[2] - up[2] * fw[1];
      c[1] = up[2] * fw[0] - up[0] * fw[2];
      c[2] = up[0] * fw[1] - up[1] * fw[0];
      cc = 0;
      for (int k = 0; k < 3; k++) cc += mag(c[k]) * mag(c[k]);
      len = isqrt(cc);
      if (len != 0) begin
        for (int k = 0; k < 3; k++) begin
          q = ((mag(c[k]) << 14) + len / 2) / len;
          side[k] = (c[k] < 0) ? -longint'(q) : longint'(q);
        end
      end
      x = 0;
      y = 0;
      for (int k = 0; k < 3; k++) begin
        x += off[k] * side[k];
        y += off[k] * fw[k];
      end
      ax = mag(x);
      ay = mag(y);
      sh = 0;
      while ((ax >> sh) >= 64'h8000_0000 || (ay >> sh) >= 64'h8000_0000) sh++;
      ax >>= sh;
      ay >>= sh;
      h = isqrt(ax * ax + ay * ay);
      if (h == 0) begin
        r.pan = sagp_pkg::PAN_LEFT;
      end else begin
        q = (ax * 32768 + h / 2) / h;
        if (x > 0) r.pan = 16'(64'd0 - q);
        else r.pan = (q > 32767) ? sagp_pkg::PAN_MAX : 16'(q);
      end
      r.pan_valid = 1'b1;
    end
    return r;
  endfunction

  // Random offset around the listener, mostly between near and far
  function automatic source_t random_source();
    source_t         s;
    longint unsigned d;
    int              b, pick;
    pick = $urandom_range(0, 99);
    s.tag = 5'($urandom);
    if (pick < 15) begin
      s.x = 20'($urandom);
      s.y = 20'($urandom);
      s.z = 20'($urandom);
      s.near_d = 24'($urandom);
      s.far_d = 24'($urandom);
      return s;
    end
    b = $urandom_range(0, 20);
    s.x = 20'(longint'($signed(lis_pos[19:0])) +
              longint'($urandom_range(0, (1 << (b + 1)) - 1)) - (longint'(1) << b));
    b = $urandom_range(0, 20);
    s.y = 20'(longint'($signed(lis_pos[39:20])) +
              longint'($urandom_range(0, (1 << (b + 1)) - 1)) - (longint'(1) << b));
    b = $urandom_range(0, 20);
    s.z = 20'(longint'($signed(lis_pos[59:40])) +
              longint'($urandom_range(0, (1 << (b + 1)) - 1)) - (longint'(1) << b));
    d = isqrt(offset_sq(s));
    if (pick < 25) begin
      // inside near
      s.near_d = 24'(d + 1 + $urandom_range(0, 1000));
      s.far_d = 24'($urandom);
    end else if (pick < 35 && d > 0) begin
      // beyond far
      s.far_d = 24'(d - 1 - $urandom_range(0, int'(d - 1 > 1000 ? 1000 : d - 1)));
      s.near_d = $urandom_range(0, 1) ? 24'(0) : s.far_d;
    end else begin
      s.near_d = 24'(d - $urandom_range(0, int'(d > 4000 ? 4000 : d)));
      s.far_d = 24'(d + 1 + $urandom_range(0, $urandom_range(0, 1) ? 50 : 60000));
    end
    return s;
  endfunction

  function automatic source_t mk_src(int x, int y, int z, int nr, int fr, int tg);
    source_t s;
    s.x = 20'(x);
    s.y = 20'(y);
    s.z = 20'(z);
    s.near_d = 24'(nr);
    s.far_d = 24'(fr);
    s.tag = 5'(tg);
    return s;
  endfunction

  task automatic cfg_write(logic [1:0] idx, logic [63:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      sagp_pkg::REG_POSITION: lis_pos = value[59:0];
      sagp_pkg::REG_FORWARD:  lis_fwd = value[47:0];
      sagp_pkg::REG_UP:       lis_up = value[47:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_q.size() != 0 || in_valid_i || expected_mix_q.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Accept source transactions and record what each should produce
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    src_taken <= in_valid_i && !in_stall_o;
    if (in_valid_i && !in_stall_o)
      expected_mix_q.push_back(gain_pan({source_x_i, source_y_i, source_z_i,
                                         near_distance_i, far_distance_i, source_tag_i}));
  end

  // Source driver: hold until taken, then idle a while or load the next item
  always @(negedge clk_i) begin
    source_t s;
    int      r;
    if (!in_valid_i || src_taken) begin
      if (src_gap > 0) begin
        src_gap <= src_gap - 1;
        in_valid_i <= 1'b0;
      end else if (pending_q.size() != 0) begin
        s = pending_q.pop_front();
        source_x_i <= s.x;
        source_y_i <= s.y;
        source_z_i <= s.z;
        near_distance_i <= s.near_d;
        far_distance_i <= s.far_d;
        source_tag_i <= s.tag;
        in_valid_i <= 1'b1;
        r = $urandom_range(0, 99);
        if (cyc[9:8] == 2'd0 || r < 60) src_gap <= 0;
        else if (r < 96) src_gap <= $urandom_range(1, 3);
        else src_gap <= $urandom_range(10, 60);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result-side backpressure
  always @(negedge clk_i) begin
    int r;
    if (stall_len > 0) begin
      stall_len <= stall_len - 1;
      out_stall_i <= 1'b1;
    end else begin
      r = $urandom_range(0, 99);
      if (cyc[9:8] == 2'd1 || r < 65) begin
        out_stall_i <= 1'b0;
      end else if (r < 96) begin
        out_stall_i <= 1'b1;
        stall_len <= $urandom_range(0, 2);
      end else begin
        out_stall_i <= 1'b1;
        stall_len <= $urandom_range(10, 60);
      end
    end
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk_i) begin
    mix_t e;
    if (out_valid_o && !out_stall_i) begin
      if (expected_mix_q.size() == 0) begin
        $error("unexpected result: gain %0d pan %0d tag %0d", gain_o, pan_o, result_tag_o);
        fail_cnt++;
      end else begin
        e = expected_mix_q.pop_front();
        if (gain_o !== e.gain) begin
          $error("gain: expected %0d, got %0d", e.gain, gain_o);
          fail_cnt++;
        end
        if (pan_o !== e.pan) begin
          $error("pan: expected %0d, got %0d", e.pan, pan_o);
          fail_cnt++;
        end
        if (pan_valid_o !== e.pan_valid) begin
          $error("pan_valid: expected %0d, got %0d", e.pan_valid, pan_valid_o);
          fail_cnt++;
        end
        if (result_tag_o !== e.tag) begin
          $error("result_tag: expected %0d, got %0d", e.tag, result_tag_o);
          fail_cnt++;
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[spatial_audio_gain_pan_core] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset listener at origin, forward +z, up +y, side +x
    pending_q.push_back(mk_src(0, 0, 0, 0, 0, 0));                  // zero span, pan hard left
    pending_q.push_back(mk_src(768, 1024, 0, 1280, 1280, 31));      // zero span on 3-4-5
    pending_q.push_back(mk_src(256, 0, 0, 512, 1024, 1));           // inside near
    pending_q.push_back(mk_src(0, 0, 4096, 0, 1024, 2));            // beyond far
    pending_q.push_back(mk_src(2560, 0, 0, 4096, 1024, 3));         // near above far
    pending_q.push_back(mk_src(2560, 0, 0, 256, 4096, 4));          // hard left
    pending_q.push_back(mk_src(-2560, 0, 0, 256, 4096, 5));         // hard right
    pending_q.push_back(mk_src(0, 0, 2560, 256, 4096, 6));          // straight ahead
    pending_q.push_back(mk_src(0, 0, -2560, 256, 4096, 7));         // straight behind
    pending_q.push_back(mk_src(-524288, -524288, -524288, 0, 24'hFFFFFF, 8));
    pending_q.push_back(mk_src(524287, 524287, 524287, 0, 24'hFFFFFF, 9));
    pending_q.push_back(mk_src(524287, -524288, 0, 24'hFFFFFF, 24'hFFFFFF, 10));
    pending_q.push_back(mk_src(-524288, 524287, 524287, 0, 0, 11));
    pending_q.push_back(mk_src(1, 1, 1, 0, 1, 12));
    pending_q.push_back(mk_src(300, 0, 300, 100, 600, 13));
    drain();

    for (int set = 0; set < 5; set++) begin
      case (set)
        0: ;
        1: begin
          cfg_write(sagp_pkg::REG_POSITION, {$urandom, $urandom});
          cfg_write(sagp_pkg::REG_FORWARD, {$urandom, $urandom});
          cfg_write(sagp_pkg::REG_UP, {$urandom, $urandom});
        end
        2: begin
          // up parallel to forward: zero side vector
          cfg_write(sagp_pkg::REG_POSITION, 64'h0FFF_FFFF_FFFF_FFFF);
          cfg_write(sagp_pkg::REG_FORWARD, 64'h0000_8000_8000_8000);
          cfg_write(sagp_pkg::REG_UP, 64'h0000_8000_8000_8000);
        end
        3: begin
          cfg_write(sagp_pkg::REG_POSITION, 64'h0800_0080_0008_0000);
          cfg_write(sagp_pkg::REG_FORWARD, 64'h0);
          cfg_write(sagp_pkg::REG_UP, {$urandom, $urandom});
        end
        default: begin
          cfg_write(sagp_pkg::REG_POSITION, {$urandom, $urandom} & 64'h0000_0FFF_FFF0_0000);
          cfg_write(sagp_pkg::REG_FORWARD, 64'h0000_7FFF_8000_7FFF);
          cfg_write(sagp_pkg::REG_UP, 64'h0000_FFFF_7FFF_0001);
        end
      endcase
      for (int i = 0; i < ITEMS_PER_SET; i++) pending_q.push_back(random_source());
      drain();
    end

    if (fail_cnt == 0) begin
      $display("[spatial_audio_gain_pan_core] OK");
    end else begin
      $display("[spatial_audio_gain_pan_core] ERROR");
    end
    $finish;
  end

endmodule
